// ===== sv/pphs_pkg.sv =====
// Package for the parallel port print handshake unit.
// Holds the shared types, codes and constants; depends on nothing.
package pphs_pkg;

   localparam int PORT_COUNT = 2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_PORT_PRESENT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_STROBE_TICKS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_INIT_TICKS   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ACK_LIMIT    = 2'd3;

   localparam logic [1:0]  PORT_PRESENT_RST = 2'd1;
   localparam logic [7:0]  STROBE_TICKS_RST = 8'd5;
   localparam logic [15:0] INIT_TICKS_RST   = 16'd4000;
   localparam logic [15:0] ACK_LIMIT_RST    = 16'h8000;

   localparam logic [7:0] STATUS_MASK  = 8'hF8;
   localparam logic [7:0] STATUS_FLIP  = 8'h48;
   localparam logic [7:0] ACK_PIN_MASK = 8'h40;
   localparam logic [7:0] TIMEOUT_FLAG = 8'h01;

   typedef enum logic [2:0] {
      ACT_TICK   = 3'd0,
      ACT_PRINT  = 3'd1,
      ACT_INIT   = 3'd2,
      ACT_STATUS = 3'd3
   } action_type;

   typedef struct packed {
      logic [1:0]  port_present;
      logic [7:0]  strobe_ticks;
      logic [15:0] init_ticks;
      logic [15:0] ack_limit;
   } cfg_type;

   typedef struct packed {
      logic [2:0] action;
      logic [1:0] port;
      logic [7:0] char_code;
      logic [7:0] status_pins;
   } req_type;

   typedef struct packed {
      logic [7:0] data_lines;
      logic       strobe_line;
      logic       init_line;
      logic       busy_res;
      logic       done_res;
      logic       carry_error;
      logic [7:0] status_byte;
   } rsp_type;

   function automatic logic [7:0] xlate(input logic [7:0] pins);
      xlate = (pins & STATUS_MASK) ^ STATUS_FLIP;
   endfunction

endpackage

// ===== sv/pphs_req_if.sv =====
// Request channel interface of the print handshake unit.
// Carries valid, ready and one command or tick; no dependencies.
interface pphs_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [1:0] port;
   logic [7:0] char_code;
   logic [7:0] status_pins;

   modport source (output valid, action, port, char_code, status_pins, input ready);
   modport sink   (input valid, action, port, char_code, status_pins, output ready);
endinterface

// ===== sv/pphs_rsp_if.sv =====
// Response channel interface of the print handshake unit.
// Carries valid, ready and the line and status result; no dependencies.
interface pphs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_lines;
   logic       strobe_line;
   logic       init_line;
   logic       busy_res;
   logic       done_res;
   logic       carry_error;
   logic [7:0] status_byte;

   modport source (output valid, data_lines, strobe_line, init_line, busy_res, done_res,
                   carry_error, status_byte, input ready);
   modport sink   (input valid, data_lines, strobe_line, init_line, busy_res, done_res,
                   carry_error, status_byte, output ready);
endinterface

// ===== sv/pphs_csr.sv =====
// Configuration registers of the print handshake unit.
// Depends on pphs_pkg for the register indexes and reset values.
module pphs_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [pphs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pphs_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output pphs_pkg::cfg_type                  cfg
);

   pphs_pkg::cfg_type cfg_ff;
   pphs_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            pphs_pkg::REG_PORT_PRESENT: cfg_in.port_present = csr_wdata[1:0];
            pphs_pkg::REG_STROBE_TICKS: cfg_in.strobe_ticks = csr_wdata[7:0];
            pphs_pkg::REG_INIT_TICKS:   cfg_in.init_ticks   = csr_wdata[15:0];
            pphs_pkg::REG_ACK_LIMIT:    cfg_in.ack_limit    = csr_wdata[15:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.port_present <= pphs_pkg::PORT_PRESENT_RST;
         cfg_ff.strobe_ticks <= pphs_pkg::STROBE_TICKS_RST;
         cfg_ff.init_ticks   <= pphs_pkg::INIT_TICKS_RST;
         cfg_ff.ack_limit    <= pphs_pkg::ACK_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/pphs_seq.sv =====
// Print, initialise and status sequencer of the print handshake unit.
// Holds the handshake state; depends on pphs_pkg for types and constants.
module pphs_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  pphs_pkg::req_type  item,
   input  pphs_pkg::cfg_type  cfg,
   output pphs_pkg::rsp_type  result
);

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_STROBE = 2'd1,
      PH_ACK    = 2'd2,
      PH_INIT   = 2'd3
   } phase_type;

   phase_type   phase_ff,    phase_in;
   logic [15:0] timer_ff,    timer_in;
   logic [15:0] attempts_ff, attempts_in;
   logic [7:0]  latch_ff,    latch_in;
   logic        strobe_ff,   strobe_in;
   logic        init_ff,     init_in;

   logic [15:0] timer_dec;
   logic [15:0] attempts_inc;
   logic [15:0] ack_lim;
   logic [15:0] strobe_load;
   logic [15:0] init_load;
   logic        port_ok;
   logic        done;
   logic        carry;
   logic [7:0]  status;

   assign timer_dec    = (timer_ff != 16'd0) ? timer_ff - 16'd1 : 16'd0;
   assign attempts_inc = attempts_ff + 16'd1;
   assign ack_lim      = (cfg.ack_limit == 16'd0) ? 16'd1 : cfg.ack_limit;
   assign strobe_load  = (cfg.strobe_ticks == 8'd0) ? 16'd1 : {8'd0, cfg.strobe_ticks};
   assign init_load    = (cfg.init_ticks == 16'd0) ? 16'd1 : cfg.init_ticks;

   // Only the two ports with a present bit can ever exist.
   assign port_ok = (int'(item.port) < pphs_pkg::PORT_COUNT) && (item.port[1] == 1'b0)
                    && cfg.port_present[item.port[0]];

   always_comb begin
      phase_in    = phase_ff;
      timer_in    = timer_ff;
      attempts_in = attempts_ff;
      latch_in    = latch_ff;
      strobe_in   = strobe_ff;
      init_in     = init_ff;
      done        = 1'b0;
      carry       = 1'b0;
      status      = 8'd0;
      case (item.action)
         pphs_pkg::ACT_TICK: begin
            case (phase_ff)
               PH_STROBE: begin
                  timer_in = timer_dec;
                  if (timer_dec == 16'd0) begin
                     strobe_in   = 1'b0;
                     attempts_in = 16'd0;
                     phase_in    = PH_ACK;
                  end
               end
               PH_ACK: begin
                  if ((item.status_pins & pphs_pkg::ACK_PIN_MASK) == 8'd0) begin
                     status   = pphs_pkg::xlate(item.status_pins);
                     done     = 1'b1;
                     phase_in = PH_IDLE;
                  end else begin
                     attempts_in = attempts_inc;
                     if (attempts_inc >= ack_lim) begin
                        status   = pphs_pkg::xlate(item.status_pins) | pphs_pkg::TIMEOUT_FLAG;
                        done     = 1'b1;
                        phase_in = PH_IDLE;
                     end
                  end
               end
               PH_INIT: begin
                  timer_in = timer_dec;
                  if (timer_dec == 16'd0) begin
                     init_in  = 1'b1;
                     status   = pphs_pkg::xlate(item.status_pins);
                     done     = 1'b1;
                     phase_in = PH_IDLE;
                  end
               end
               default: phase_in = phase_ff;
            endcase
         end
         pphs_pkg::ACT_PRINT, pphs_pkg::ACT_INIT, pphs_pkg::ACT_STATUS: begin
            // Commands that arrive during a running sequence are dropped silently.
            if (phase_ff == PH_IDLE) begin
               if (!port_ok) begin
                  carry = 1'b1;
               end else if (item.action == pphs_pkg::ACT_PRINT) begin
                  latch_in    = item.char_code;
                  strobe_in   = 1'b1;
                  timer_in    = strobe_load;
                  attempts_in = 16'd0;
                  phase_in    = PH_STROBE;
               end else if (item.action == pphs_pkg::ACT_INIT) begin
                  init_in  = 1'b0;
                  timer_in = init_load;
                  phase_in = PH_INIT;
               end else begin
                  status = pphs_pkg::xlate(item.status_pins);
                  done   = 1'b1;
               end
            end
         end
         default: carry = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         timer_ff    <= 16'd0;
         attempts_ff <= 16'd0;
         latch_ff    <= 8'd0;
         strobe_ff   <= 1'b0;
         init_ff     <= 1'b1;
      end else if (fire) begin
         phase_ff    <= phase_in;
         timer_ff    <= timer_in;
         attempts_ff <= attempts_in;
         latch_ff    <= latch_in;
         strobe_ff   <= strobe_in;
         init_ff     <= init_in;
      end
   end

   assign result.data_lines  = latch_in;
   assign result.strobe_line = strobe_in;
   assign result.init_line   = init_in;
   assign result.busy_res    = (phase_in != PH_IDLE);
   assign result.done_res    = done;
   assign result.carry_error = carry;
   assign result.status_byte = status;

endmodule

// ===== sv/parallel_port_print_handshake_unit.sv =====
// Top level of the parallel port print handshake unit.
// Depends on pphs_pkg, pphs_req_if, pphs_rsp_if, pphs_csr and pphs_seq.
//
//   Channel    Direction  Transaction
//   req_chan   in         one tick or command (action, port, char_code, status_pins)
//   rsp_chan   out        one result per request (lines, busy, done, carry, status)
//   csr_*      in         register write, index 0 to 3, no read-back
//
// Each request is registered on acceptance, passes the sequencer logic and lands in the
// result register; one transaction per cycle is sustained while the result side is not
// stalled. The sequencer state advances only when a registered request moves to the
// result register. A stalled result register holds the request register, and one
// further request is still taken while a result waits. Reset is synchronous and
// returns all control state to idle with strobe released and init high.
module parallel_port_print_handshake_unit (
   input  logic                               clock,
   input  logic                               reset,
   pphs_req_if.sink                           req_chan,
   pphs_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [pphs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pphs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   pphs_pkg::cfg_type cfg;
   pphs_pkg::rsp_type result;

   logic              in_valid_ff,  in_valid_in;
   pphs_pkg::req_type in_item_ff;
   logic              out_valid_ff, out_valid_in;
   pphs_pkg::rsp_type out_data_ff;

   logic accept;
   logic advance;
   logic fire;

   assign advance = !out_valid_ff || rsp_chan.ready;
   assign fire    = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept  = req_chan.valid && req_chan.ready;

   assign in_valid_in  = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign out_valid_in = fire ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   pphs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pphs_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.action      <= req_chan.action;
         in_item_ff.port        <= req_chan.port;
         in_item_ff.char_code   <= req_chan.char_code;
         in_item_ff.status_pins <= req_chan.status_pins;
      end
      if (fire) begin
         out_data_ff <= result;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.data_lines  = out_data_ff.data_lines;
   assign rsp_chan.strobe_line = out_data_ff.strobe_line;
   assign rsp_chan.init_line   = out_data_ff.init_line;
   assign rsp_chan.busy_res    = out_data_ff.busy_res;
   assign rsp_chan.done_res    = out_data_ff.done_res;
   assign rsp_chan.carry_error = out_data_ff.carry_error;
   assign rsp_chan.status_byte = out_data_ff.status_byte;

   // A finished command and an error never come from the same transaction.
   a_done_not_carry: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.done_res && rsp_chan.carry_error))
      else $error("done and carry both set");

   // With no sequence running, strobe is released and init is high.
   a_idle_lines: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.busy_res) |->
         (!rsp_chan.strobe_line && rsp_chan.init_line))
      else $error("control lines active while idle");

   // Status is only reported on a finishing transaction.
   a_status_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.done_res) |-> (rsp_chan.status_byte == 8'd0))
      else $error("status without done");

   // A request held in the input register moves on once the result side is free.
   a_no_lost_request: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && advance) |=> out_valid_ff)
      else $error("request did not reach the result register");

endmodule
